/* rtl/hcbd_pkg.sv */
package hcbd_pkg;

    // Target codes
    localparam logic [3:0] TGT_RAM    = 4'd0;
    localparam logic [3:0] TGT_ROM    = 4'd1;
    localparam logic [3:0] TGT_VIC    = 4'd2;
    localparam logic [3:0] TGT_SID    = 4'd3;
    localparam logic [3:0] TGT_COLOUR = 4'd4;
    localparam logic [3:0] TGT_CIA1   = 4'd5;
    localparam logic [3:0] TGT_CIA2   = 4'd6;
    localparam logic [3:0] TGT_EXP    = 4'd7;
    localparam logic [3:0] TGT_PORT   = 4'd8;

    // Access kinds
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Address map
    localparam logic [15:0] ADDR_CART_LO  = 16'h8000;
    localparam logic [15:0] ADDR_BASIC_LO = 16'hA000;
    localparam logic [15:0] ADDR_HIMEM_LO = 16'hC000;
    localparam logic [15:0] ADDR_IO_LO    = 16'hD000;
    localparam logic [15:0] ADDR_SID_LO   = 16'hD400;
    localparam logic [15:0] ADDR_COLOUR   = 16'hD800;
    localparam logic [15:0] ADDR_COLOUR_HI = 16'hDBFF;
    localparam logic [15:0] ADDR_CIA2_LO  = 16'hDD00;
    localparam logic [15:0] ADDR_EXP      = 16'hDE00;
    localparam logic [15:0] ADDR_KERNEL_LO = 16'hE000;

    localparam logic [15:0] MASK_VIC = 16'h003F;
    localparam logic [15:0] MASK_SID = 16'h001F;
    localparam logic [15:0] MASK_CIA = 16'h000F;

    localparam logic [7:0] PORT_DIR_RESET = 8'h2F;
    localparam logic [7:0] PORT_VAL_RESET = 8'h1F;

    typedef struct packed {
        logic [7:0] port_direction;
        logic [7:0] port_value;
        logic       kernel_visible;
        logic       basic_visible;
        logic       char_visible;
        logic       io_visible;
    } bank_state_t;

    typedef struct packed {
        logic        func;
        logic [15:0] address;
        logic [7:0]  write_byte;
        logic [7:0]  external_port_bits;
    } access_t;

    typedef struct packed {
        logic [3:0]  target;
        logic [15:0] device_address;
        logic [7:0]  device_write_byte;
        logic [7:0]  port_read_byte;
        logic        bank_switch;
        logic [5:0]  bank_number;
    } route_t;

endpackage

/* rtl/hcbd_if.sv */
interface hcbd_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] address;
    logic [7:0]  write_byte;
    logic [7:0]  external_port_bits;

    modport source (output valid, output func, output address, output write_byte,
                    output external_port_bits, input ready);
    modport sink   (input valid, input func, input address, input write_byte,
                    input external_port_bits, output ready);
endinterface

interface hcbd_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  target;
    logic [15:0] device_address;
    logic [7:0]  device_write_byte;
    logic [7:0]  port_read_byte;
    logic        bank_switch;
    logic [5:0]  bank_number;

    modport source (output valid, output target, output device_address,
                    output device_write_byte, output port_read_byte,
                    output bank_switch, output bank_number, input ready);
    modport sink   (input valid, input target, input device_address,
                    input device_write_byte, input port_read_byte,
                    input bank_switch, input bank_number, output ready);
endinterface

interface hcbd_cfg_if;
    logic valid;
    logic ready;
    logic cartridge_visible;

    modport source (output valid, output cartridge_visible, input ready);
    modport sink   (input valid, input cartridge_visible, output ready);
endinterface

/* rtl/home_computer_bank_decoder.sv */
// An accepted item waits in the input register, and its route is written to the result
// register when that register is free or being emptied.
// Throughput: one item per cycle; the input side stalls only while the result is held.
// Reset (rst_n, asynchronous, active low) empties both registers, sets the port
// direction to 2F, the port data to 1F, kernel, basic and I/O visible, character ROM
// hidden and the cartridge hidden.
module home_computer_bank_decoder
    import hcbd_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    hcbd_in_if.sink      item_in,
    hcbd_out_if.source   item_out,
    hcbd_cfg_if.sink     cfg
);

    // Input register: one access waiting to be decoded
    logic        in_valid_reg;
    access_t     in_item_reg;

    // Result register
    logic        out_valid_reg;
    route_t      out_item_reg;

    // Port and visibility state, plus the cartridge setting
    bank_state_t state_reg;
    bank_state_t state_next;
    logic        cartridge_visible_reg;

    route_t      route;
    logic        advance;

    // Move the held access to the result register whenever that slot is free or
    // being emptied; the state changes at the same edge, so accesses apply in order.
    assign advance      = in_valid_reg && (!out_valid_reg || item_out.ready);
    assign item_in.ready = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cartridge_visible_reg <= 1'b0;
        else if (cfg.valid)
            cartridge_visible_reg <= cfg.cartridge_visible;
    end

    // Capture a new item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_in.ready)
            in_valid_reg <= item_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            in_item_reg.func               <= item_in.func;
            in_item_reg.address            <= item_in.address;
            in_item_reg.write_byte         <= item_in.write_byte;
            in_item_reg.external_port_bits <= item_in.external_port_bits;
        end
    end

    hcbd_decode u_decode (
        .acc               (in_item_reg),
        .state             (state_reg),
        .cartridge_visible (cartridge_visible_reg),
        .route             (route),
        .state_next        (state_next)
    );

    // Commit port and flag updates only when the access leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.port_direction <= PORT_DIR_RESET;
            state_reg.port_value     <= PORT_VAL_RESET;
            state_reg.kernel_visible <= 1'b1;
            state_reg.basic_visible  <= 1'b1;
            state_reg.char_visible   <= 1'b0;
            state_reg.io_visible     <= 1'b1;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // Result register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (item_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= route;
    end

    assign item_out.valid             = out_valid_reg;
    assign item_out.target            = out_item_reg.target;
    assign item_out.device_address    = out_item_reg.device_address;
    assign item_out.device_write_byte = out_item_reg.device_write_byte;
    assign item_out.port_read_byte    = out_item_reg.port_read_byte;
    assign item_out.bank_switch       = out_item_reg.bank_switch;
    assign item_out.bank_number       = out_item_reg.bank_number;

    // A bank request can only come from the expansion page
    a_bank_is_expansion: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.bank_switch |-> out_item_reg.target == TGT_EXP)
        else $error("bank switch on a non-expansion route");

    // No bank number without a request
    a_bank_number_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.bank_switch |-> out_item_reg.bank_number == 6'd0)
        else $error("bank number without bank switch");

    // Port read data only on port accesses
    a_port_read_only_port: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.target != TGT_PORT
            |-> out_item_reg.port_read_byte == 8'd0)
        else $error("port read byte on a non-port route");

    // Character ROM and I/O never share the D000 page
    a_char_io_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.char_visible && state_reg.io_visible))
        else $error("character ROM and I/O both visible");

    // Flags move only when an access leaves the input register
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("port state changed without an access");

endmodule

/* rtl/hcbd_decode.sv */
module hcbd_decode
    import hcbd_pkg::*;
(
    input  access_t     acc,
    input  bank_state_t state,
    input  logic        cartridge_visible,
    output route_t      route,
    output bank_state_t state_next
);

    logic        is_port;
    logic        is_write;
    logic        in_io;
    logic [7:0]  dir_new;
    logic [7:0]  val_new;
    logic [7:0]  lines;
    logic [3:0]  io_target;
    logic [15:0] io_dev;

    assign is_port  = (acc.address[15:1] == 15'd0);
    assign is_write = (acc.func == FUNC_WRITE);
    assign in_io    = (acc.address >= ADDR_IO_LO) && (acc.address < ADDR_KERNEL_LO);

    // Port registers as they stand after this access
    always_comb
    begin
        dir_new = state.port_direction;
        val_new = state.port_value;
        if (is_port && is_write)
        begin
            if (acc.address[0] == 1'b0)
                dir_new = acc.write_byte;
            else
                val_new = acc.write_byte;
        end
        lines = (dir_new & val_new) | (~dir_new & acc.external_port_bits);
    end

    always_comb
    begin
        state_next = state;
        if (is_port && is_write)
        begin
            state_next.port_direction = dir_new;
            state_next.port_value     = val_new;
            state_next.kernel_visible = lines[1];
            state_next.basic_visible  = (lines[1:0] == 2'b11);
            state_next.char_visible   = !lines[2] && (lines[1:0] != 2'b00);
            state_next.io_visible     = lines[2] && (lines[1:0] != 2'b00);
        end
    end

    // I/O page split
    always_comb
    begin
        if (acc.address < ADDR_SID_LO)
        begin
            io_target = TGT_VIC;
            io_dev    = acc.address & MASK_VIC;
        end
        else if (acc.address < ADDR_COLOUR)
        begin
            io_target = TGT_SID;
            io_dev    = acc.address & MASK_SID;
        end
        else if (acc.address <= ADDR_COLOUR_HI)
        begin
            io_target = TGT_COLOUR;
            io_dev    = acc.address - ADDR_COLOUR;
        end
        else if (acc.address < ADDR_CIA2_LO)
        begin
            io_target = TGT_CIA1;
            io_dev    = acc.address & MASK_CIA;
        end
        else if (acc.address < ADDR_EXP)
        begin
            io_target = TGT_CIA2;
            io_dev    = acc.address & MASK_CIA;
        end
        else
        begin
            io_target = TGT_EXP;
            io_dev    = acc.address - ADDR_EXP;
        end
    end

    always_comb
    begin
        route                   = '0;
        route.device_address    = acc.address;
        route.target            = TGT_RAM;
        if (is_port)
        begin
            route.target         = TGT_PORT;
            route.port_read_byte = acc.address[0] ? lines : dir_new;
            if (is_write)
                route.device_write_byte = acc.write_byte;
        end
        else if (is_write)
        begin
            route.device_write_byte = acc.write_byte;
            if (in_io && state.io_visible)
            begin
                route.target         = io_target;
                route.device_address = io_dev;
                if (io_target == TGT_COLOUR)
                    route.device_write_byte = {4'd0, acc.write_byte[3:0]};
                if (cartridge_visible && acc.address == ADDR_EXP)
                begin
                    route.bank_switch = 1'b1;
                    route.bank_number = acc.write_byte[5:0];
                end
            end
        end
        else
        begin
            if (acc.address < ADDR_CART_LO)
                route.target = TGT_RAM;
            else if (acc.address < ADDR_BASIC_LO)
                route.target = cartridge_visible ? TGT_ROM : TGT_RAM;
            else if (acc.address < ADDR_HIMEM_LO)
                route.target = (state.basic_visible || cartridge_visible) ? TGT_ROM
                                                                           : TGT_RAM;
            else if (acc.address < ADDR_IO_LO)
                route.target = TGT_RAM;
            else if (acc.address < ADDR_KERNEL_LO)
            begin
                if (state.io_visible)
                begin
                    route.target         = io_target;
                    route.device_address = io_dev;
                end
                else
                    route.target = state.char_visible ? TGT_ROM : TGT_RAM;
            end
            else
                route.target = state.kernel_visible ? TGT_ROM : TGT_RAM;
        end
    end

endmodule

/* tb/sv/home_computer_bank_decoder_test.sv */
module home_computer_bank_decoder_test
    import hcbd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Longest stretch without any handshake before the run is declared hung.
    // Natural gaps are at most a sender wait plus a receiver stall plus the
    // passage through the input and result registers, so this is far above any correct run.
    localparam int IDLE_LIMIT  = 1000;
    localparam int ITEMS_PHASE = 260;
    localparam int PHASES      = 5;
    localparam int MAX_WAIT    = 13;
    localparam int MAX_REPORTS = 10;

    // Predicts the route of every accepted item and holds the routes still
    // owed by the block, oldest first.
    class route_scoreboard;
        logic [7:0] port_dir;
        logic [7:0] port_val;
        logic       kernel_on;
        logic       basic_on;
        logic       char_on;
        logic       io_on;
        logic       cart_on;
        route_t     owed_routes[$];
        int         mismatches;

        function new();
            port_dir   = PORT_DIR_RESET;
            port_val   = PORT_VAL_RESET;
            kernel_on  = 1'b1;
            basic_on   = 1'b1;
            char_on    = 1'b0;
            io_on      = 1'b1;
            cart_on    = 1'b0;
            mismatches = 0;
        endfunction

        function void set_cartridge(input logic vis);
            cart_on = vis;
        endfunction

        function int pending();
            return owed_routes.size();
        endfunction

        // Output pins drive the data register, input pins follow the outside.
        function logic [7:0] pin_levels(input logic [7:0] ext);
            return (port_dir & port_val) | (~port_dir & ext);
        endfunction

        function void decode_io(input logic [15:0] ad, inout route_t r);
            if (ad < ADDR_SID_LO)
            begin
                r.target = TGT_VIC;
                r.device_address = ad & MASK_VIC;
            end
            else if (ad < ADDR_COLOUR)
            begin
                r.target = TGT_SID;
                r.device_address = ad & MASK_SID;
            end
            else if (ad <= ADDR_COLOUR_HI)
            begin
                r.target = TGT_COLOUR;
                r.device_address = ad - ADDR_COLOUR;
            end
            else if (ad < ADDR_CIA2_LO)
            begin
                r.target = TGT_CIA1;
                r.device_address = ad & MASK_CIA;
            end
            else if (ad < ADDR_EXP)
            begin
                r.target = TGT_CIA2;
                r.device_address = ad & MASK_CIA;
            end
            else
            begin
                r.target = TGT_EXP;
                r.device_address = ad - ADDR_EXP;
            end
        endfunction

        function void note_access(input access_t acc);
            route_t     r;
            logic [15:0] ad;
            logic [7:0] pins;
            ad = acc.address;
            r = '0;
            r.target = TGT_RAM;
            r.device_address = ad;
            if (ad <= 16'd1)
            begin
                r.target = TGT_PORT;
                if (acc.func == FUNC_WRITE)
                begin
                    r.device_write_byte = acc.write_byte;
                    if (ad == 16'd0)
                        port_dir = acc.write_byte;
                    else
                        port_val = acc.write_byte;
                    pins = pin_levels(acc.external_port_bits);
                    kernel_on = pins[1];
                    basic_on  = &pins[1:0];
                    char_on   = !pins[2] && (|pins[1:0]);
                    io_on     = pins[2] && (|pins[1:0]);
                end
                r.port_read_byte = (ad == 16'd0) ? port_dir
                                                 : pin_levels(acc.external_port_bits);
            end
            else if (acc.func == FUNC_WRITE)
            begin
                r.device_write_byte = acc.write_byte;
                if (ad >= ADDR_IO_LO && ad < ADDR_KERNEL_LO && io_on)
                begin
                    decode_io(ad, r);
                    if (r.target == TGT_COLOUR)
                        r.device_write_byte = acc.write_byte & 8'h0F;
                    if (r.target == TGT_EXP && cart_on && ad == ADDR_EXP)
                    begin
                        r.bank_switch = 1'b1;
                        r.bank_number = acc.write_byte[5:0];
                    end
                end
            end
            else
            begin
                if (ad < ADDR_CART_LO)
                    r.target = TGT_RAM;
                else if (ad < ADDR_BASIC_LO)
                    r.target = cart_on ? TGT_ROM : TGT_RAM;
                else if (ad < ADDR_HIMEM_LO)
                    r.target = (basic_on || cart_on) ? TGT_ROM : TGT_RAM;
                else if (ad < ADDR_IO_LO)
                    r.target = TGT_RAM;
                else if (ad < ADDR_KERNEL_LO)
                begin
                    if (io_on)
                        decode_io(ad, r);
                    else
                        r.target = char_on ? TGT_ROM : TGT_RAM;
                end
                else
                    r.target = kernel_on ? TGT_ROM : TGT_RAM;
            end
            owed_routes.push_back(r);
        endfunction

        function void check_route(input route_t got);
            route_t want;
            string  bad;
            if (owed_routes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected route: tgt=%0d addr=%h wb=%h prb=%h sw=%b bank=%h",
                             got.target, got.device_address, got.device_write_byte,
                             got.port_read_byte, got.bank_switch, got.bank_number);
                return;
            end
            want = owed_routes.pop_front();
            bad = "";
            if (got.target !== want.target)                       bad = {bad, " target"};
            if (got.device_address !== want.device_address)       bad = {bad, " address"};
            if (got.device_write_byte !== want.device_write_byte) bad = {bad, " write_byte"};
            if (got.port_read_byte !== want.port_read_byte)       bad = {bad, " port_byte"};
            if (got.bank_switch !== want.bank_switch)             bad = {bad, " switch"};
            if (got.bank_number !== want.bank_number)             bad = {bad, " bank"};
            if (bad != "")
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("route mismatch (%s ):", bad);
                    $display("  expected tgt=%0d addr=%h wb=%h prb=%h sw=%b bank=%h",
                             want.target, want.device_address,
                             want.device_write_byte, want.port_read_byte,
                             want.bank_switch, want.bank_number);
                    $display("  got      tgt=%0d addr=%h wb=%h prb=%h sw=%b bank=%h",
                             got.target, got.device_address, got.device_write_byte,
                             got.port_read_byte, got.bank_switch, got.bank_number);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    hcbd_in_if  in_bus();
    hcbd_out_if out_bus();
    hcbd_cfg_if cfg_bus();

    route_scoreboard sb;

    // When set, the matching side stops idling for a stretch of items.
    bit in_calm;
    bit out_calm;
    int idle_cycles;

    home_computer_bank_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_in  (in_bus),
        .item_out (out_bus),
        .cfg      (cfg_bus)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Sample every handshake at the rising edge. Inputs only move on the
    // falling edge, so the values seen here are the ones the block latched.
    always @(posedge clk)
    begin
        route_t  got;
        access_t acc;
        bit      moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                sb.set_cartridge(cfg_bus.cartridge_visible);
                moved = 1'b1;
            end
            if (out_bus.valid && out_bus.ready)
            begin
                got.target            = out_bus.target;
                got.device_address    = out_bus.device_address;
                got.device_write_byte = out_bus.device_write_byte;
                got.port_read_byte    = out_bus.port_read_byte;
                got.bank_switch       = out_bus.bank_switch;
                got.bank_number       = out_bus.bank_number;
                sb.check_route(got);
                moved = 1'b1;
            end
            if (in_bus.valid && in_bus.ready)
            begin
                acc.func               = in_bus.func;
                acc.address            = in_bus.address;
                acc.write_byte         = in_bus.write_byte;
                acc.external_port_bits = in_bus.external_port_bits;
                sb.note_access(acc);
                moved = 1'b1;
            end
        end
        // Watchdog: count cycles in which nothing at all is handed over.
        if (moved)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before each item, then
    // hold ready until one is taken.
    initial
    begin
        int stall;
        out_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = draw_wait(out_calm);
            if (stall > 0)
            begin
                out_bus.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_bus.ready = 1'b1;
            do @(posedge clk); while (!out_bus.valid);
        end
    end

    // Enter and leave at a falling edge. Valid stays high into the next item
    // when no wait is drawn, so it is never dropped and raised in one step.
    task automatic send_access(input logic func, input logic [15:0] addr,
                               input logic [7:0] wbyte, input logic [7:0] ext);
        int gap;
        gap = draw_wait(in_calm);
        if (gap > 0)
        begin
            in_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_bus.valid              = 1'b1;
        in_bus.func               = func;
        in_bus.address            = addr;
        in_bus.write_byte         = wbyte;
        in_bus.external_port_bits = ext;
        do @(posedge clk); while (!in_bus.ready);
        @(negedge clk);
    endtask

    // Drop valid, hold until every owed route has come back, and let the block idle before returning.
    task automatic drain();
        in_bus.valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_cartridge(input logic vis);
        cfg_bus.valid             = 1'b1;
        cfg_bus.cartridge_visible = vis;
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // Random access biased towards the port, the I/O page and the area
    // boundaries, where the decoding actually branches.
    task automatic send_random();
        logic [15:0] addr;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            addr = 16'($urandom_range(0, 1));
        else if (pick < 20)
            addr = ADDR_EXP;
        else if (pick < 55)
            addr = 16'($urandom_range(ADDR_IO_LO, 16'hDFFF));
        else if (pick < 65)
        begin
            case ($urandom_range(0, 9))
                0: addr = ADDR_CART_LO;
                1: addr = ADDR_BASIC_LO;
                2: addr = ADDR_HIMEM_LO;
                3: addr = ADDR_IO_LO;
                4: addr = ADDR_SID_LO;
                5: addr = ADDR_COLOUR;
                6: addr = ADDR_COLOUR_HI + 16'd1;
                7: addr = ADDR_CIA2_LO;
                8: addr = ADDR_KERNEL_LO;
                default: addr = 16'd2;
            endcase
            addr = addr - 16'($urandom_range(0, 1));
        end
        else
            addr = 16'($urandom_range(0, 16'hFFFF));
        send_access(logic'($urandom_range(0, 1)), addr,
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        sb = new();
        idle_cycles               = 0;
        in_calm                   = 1'b0;
        out_calm                  = 1'b0;
        in_bus.valid              = 1'b0;
        in_bus.func               = FUNC_READ;
        in_bus.address            = '0;
        in_bus.write_byte         = '0;
        in_bus.external_port_bits = '0;
        cfg_bus.valid             = 1'b0;
        cfg_bus.cartridge_visible = 1'b0;
        rst_n                     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_cartridge(1'b0);

        // Port reads: direction register, then pin levels with inputs high.
        send_access(FUNC_READ, 16'h0000, 8'h00, 8'h00);
        send_access(FUNC_READ, 16'h0001, 8'h00, 8'hFF);
        // Default map, cartridge hidden.
        send_access(FUNC_READ, 16'h0002, 8'h00, 8'h00);
        send_access(FUNC_READ, ADDR_CART_LO, 8'h00, 8'h00);
        send_access(FUNC_READ, ADDR_BASIC_LO, 8'h00, 8'h00);
        send_access(FUNC_READ, ADDR_IO_LO, 8'h00, 8'h00);
        send_access(FUNC_READ, ADDR_SID_LO, 8'h00, 8'h00);
        send_access(FUNC_READ, ADDR_COLOUR_HI, 8'h00, 8'h00);
        send_access(FUNC_READ, 16'hDC0F, 8'h00, 8'h00);
        send_access(FUNC_READ, 16'hDFFF, 8'h00, 8'h00);
        send_access(FUNC_READ, 16'hFFFF, 8'h00, 8'h00);
        // Colour RAM keeps the low nibble; expansion write without cartridge.
        send_access(FUNC_WRITE, ADDR_COLOUR, 8'hFF, 8'h00);
        send_access(FUNC_WRITE, ADDR_EXP, 8'hFF, 8'h00);
        // Write under ROM lands in RAM.
        send_access(FUNC_WRITE, ADDR_BASIC_LO, 8'h55, 8'h00);
        // Clear the port data: every area falls back to RAM.
        send_access(FUNC_WRITE, 16'h0001, 8'h00, 8'hFF);
        send_access(FUNC_READ, ADDR_KERNEL_LO, 8'h00, 8'hFF);
        send_access(FUNC_WRITE, 16'hD020, 8'hAA, 8'h00);
        // Only the pins moved: the flags must not follow.
        send_access(FUNC_READ, ADDR_IO_LO, 8'h00, 8'h07);
        // All pins outputs, then character ROM in place of I/O.
        send_access(FUNC_WRITE, 16'h0000, 8'hFF, 8'h00);
        send_access(FUNC_WRITE, 16'h0001, 8'h1B, 8'h00);
        send_access(FUNC_READ, ADDR_IO_LO, 8'h00, 8'h00);
        send_access(FUNC_WRITE, 16'h0001, 8'h1F, 8'h00);
        drain();

        write_cartridge(1'b1);
        send_access(FUNC_READ, ADDR_CART_LO, 8'h00, 8'h00);
        // Bank switch request with the widest bank number, then a
        // neighbouring expansion write that must not request one.
        send_access(FUNC_WRITE, ADDR_EXP, 8'hFF, 8'h00);
        send_access(FUNC_WRITE, 16'hDE01, 8'h12, 8'h00);
        // BASIC hidden but the cartridge still maps A000.
        send_access(FUNC_WRITE, 16'h0001, 8'h1C, 8'h00);
        send_access(FUNC_READ, ADDR_BASIC_LO, 8'h00, 8'h00);
        send_access(FUNC_WRITE, 16'h0001, 8'h1F, 8'h00);

        // Random phases, alternating the cartridge between its two settings.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            write_cartridge(logic'(phase % 2));
            for (int n = 0; n < ITEMS_PHASE; n++)
            begin
                if (n % 50 == 0)
                begin
                    in_calm  = ($urandom_range(0, 3) == 0);
                    out_calm = ($urandom_range(0, 3) == 0);
                end
                // Hold the sender once mid-phase until the block has caught up.
                if (phase == 2 && n == ITEMS_PHASE / 2)
                    drain();
                send_random();
            end
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* home_computer_bank_decoder.f */
rtl/hcbd_pkg.sv
rtl/hcbd_if.sv
rtl/hcbd_decode.sv
rtl/home_computer_bank_decoder.sv
tb/sv/home_computer_bank_decoder_test.sv
